// File: hw/rtl/blinn_phong_light_terms_defines.svh
// assertion macros for the shading pipeline
`ifndef BLINN_PHONG_LIGHT_TERMS_DEFINES_SVH
`define BLINN_PHONG_LIGHT_TERMS_DEFINES_SVH
`ifndef SYNTH
`define BPLT_CHECK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("bplt check failed");
`define BPLT_NEVER(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	!(expr)) else $error("bplt forbidden condition");
`else
`define BPLT_CHECK(lbl, prop)
`define BPLT_NEVER(lbl, expr)
`endif
`endif

// File: hw/rtl/bplt_pkg.sv
package bplt_pkg;
	localparam int RAD_W  = 54;
	localparam int ROOT_W = 27;
	localparam int NUM_W  = 60;
	localparam int QUO_W  = 32;
	localparam int Q30_W  = 32;
	localparam logic [Q30_W-1:0] Q30_ONE = 32'h4000_0000;
	localparam logic [Q30_W-1:0] Q30_CAP = 32'h8000_0000;
	localparam logic [15:0] Q15_ONE = 16'h8000;

	// round half up to q2.30 and cap at 2.0
	function automatic logic [Q30_W-1:0] round_cap_q30(input logic [63:0] p);
		logic [34:0] r;
		r = {1'b0, p[63:30]} + 35'(p[29]);
		return (r > 35'(Q30_CAP)) ? Q30_CAP : r[Q30_W-1:0];
	endfunction
endpackage

// File: hw/rtl/blinn_phong_light_terms.sv
// Lambert diffuse and Blinn-Phong specular terms, one hit point per item.
// Input channel s_*: one item carries normal, light and view vectors, the
// attenuation and the shininess exponent, packed in s_tdata. Output channel
// m_*: one item per input item, in order, diffuse and specular in Q1.15.
// Throughput: one item per cycle with no stall. The pipeline holds five setup
// stages, a 27-stage square root, a numerator stage, a 33-stage divider for the
// normalized cosine, a clamp stage, four stages per exponent bit for
// square-and-multiply (square, round, multiply, round), two stages for the
// attenuation, and the output queue.
// The output side is a two-entry queue; the whole pipeline advances while the
// queue has room, so a stalled receiver holds everything in place and nothing
// is dropped or repeated. s_tready stays high while the queue is not full.
// Reset empties the pipeline and the queue; no result is pending afterward.
`include "blinn_phong_light_terms_defines.svh"
module blinn_phong_light_terms
	import bplt_pkg::*;
#(
	parameter int COMPONENT_BITS = 16,
	parameter int EXPONENT_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// normal_x, normal_y, normal_z, light_x, light_y, light_z, view_x, view_y,
	// view_z, atten, shininess
	input  logic [((9*COMPONENT_BITS+16+EXPONENT_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// diffuse_term, specular_term
	output logic [31:0] m_tdata
);
	localparam int CB     = COMPONENT_BITS;
	localparam int EB     = EXPONENT_BITS;
	localparam int PW_N   = 4*EB;

	typedef struct packed {
		logic          nh_pos;
		logic          hh_nz;
		logic [32:0]   nh;
		logic [15:0]   diffuse;
		logic [15:0]   atten;
		logic [EB-1:0] k;
	} side_t;

	typedef struct packed {
		logic [Q30_W-1:0] acc;
		logic [63:0]      prod;
		logic [Q30_W-1:0] c;
		logic             hh_nz;
		logic [15:0]      diffuse;
		logic [15:0]      atten;
		logic [EB-1:0]    k;
	} pw_t;

	logic en;
	logic push;
	logic pop;
	logic [1:0] cnt_q;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	// input conversion to q2.14
	logic signed [15:0] comp [0:8];
	for (genvar g = 0; g < 9; g++) begin : g_conv
		logic [CB-1:0] raw;
		assign raw = s_tdata[g*CB +: CB];
		if (CB >= 16) begin : g_trunc
			assign comp[g] = raw[CB-1 -: 16];
		end else begin : g_pad
			assign comp[g] = {raw, {(16-CB){1'b0}}};
		end
	end

	// stage 1
	logic               vld_s1;
	logic signed [15:0] n_s1 [0:2];
	logic signed [15:0] l_s1 [0:2];
	logic signed [16:0] h_s1 [0:2];
	logic [15:0]        atten_s1;
	logic [EB-1:0]      k_s1;

	// stage 2
	logic               vld_s2;
	logic signed [31:0] pl_s2  [0:2];
	logic signed [32:0] ph_s2  [0:2];
	logic signed [33:0] phh_s2 [0:2];
	logic [15:0]        atten_s2;
	logic [EB-1:0]      k_s2;

	// stage 3
	logic               vld_s3;
	logic               nl_pos_s3;
	logic [31:0]        nl_s3;
	logic               nh_pos_s3;
	logic [32:0]        nh_s3;
	logic               hh_nz_s3;
	logic [33:0]        hh_s3;
	logic [15:0]        atten_s3;
	logic [EB-1:0]      k_s3;

	// stage 4
	logic               vld_s4;
	logic [47:0]        dprod_s4;
	side_t              side_s4;
	logic [33:0]        hh_s4;

	// stage 5
	logic               vld_s5;
	side_t              side_s5;
	logic [33:0]        hh_s5;

	logic signed [33:0] nl_sum;
	logic signed [34:0] nh_sum;
	logic signed [34:0] hh_sum;
	logic [20:0]        d_round;

	always_comb begin
		nl_sum = 34'(pl_s2[0]) + 34'(pl_s2[1]) + 34'(pl_s2[2]);
		nh_sum = 35'(ph_s2[0]) + 35'(ph_s2[1]) + 35'(ph_s2[2]);
		hh_sum = 35'(phh_s2[0]) + 35'(phh_s2[1]) + 35'(phh_s2[2]);
		d_round = {1'b0, dprod_s4[47:28]} + 21'(dprod_s4[27]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s1[i]   <= comp[i];
				l_s1[i]   <= comp[3+i];
				h_s1[i]   <= 17'(comp[3+i]) + 17'(comp[6+i]);
				pl_s2[i]  <= n_s1[i] * l_s1[i];
				ph_s2[i]  <= 33'(n_s1[i]) * 33'(h_s1[i]);
				phh_s2[i] <= 34'(h_s1[i]) * 34'(h_s1[i]);
			end
			atten_s1 <= s_tdata[9*CB +: 16];
			k_s1     <= s_tdata[9*CB+16 +: EB];
			atten_s2 <= atten_s1;
			k_s2     <= k_s1;

			nl_pos_s3 <= (nl_sum > 0);
			nl_s3     <= nl_sum[31:0];
			nh_pos_s3 <= (nh_sum > 0);
			nh_s3     <= nh_sum[32:0];
			hh_nz_s3  <= (hh_sum != 0);
			hh_s3     <= hh_sum[33:0];
			atten_s3  <= atten_s2;
			k_s3      <= k_s2;

			dprod_s4         <= nl_pos_s3 ? (nl_s3 * atten_s3) : '0;
			side_s4.nh_pos   <= nh_pos_s3;
			side_s4.hh_nz    <= hh_nz_s3;
			side_s4.nh       <= nh_s3;
			side_s4.diffuse  <= '0;
			side_s4.atten    <= atten_s3;
			side_s4.k        <= k_s3;
			hh_s4            <= hh_s3;

			side_s5.nh_pos  <= side_s4.nh_pos;
			side_s5.hh_nz   <= side_s4.hh_nz;
			side_s5.nh      <= side_s4.nh;
			side_s5.atten   <= side_s4.atten;
			side_s5.k       <= side_s4.k;
			side_s5.diffuse <= (d_round > 21'(Q15_ONE)) ? Q15_ONE : d_round[15:0];
			hh_s5           <= hh_s4;
		end
	end

	// length of the half vector
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	bplt_isqrt #(
		.SIDE_W($bits(side_t))
	) u_isqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (vld_s5),
		.in_radicand ({hh_s5, 20'd0}),
		.in_side     (side_s5),
		.out_valid   (sq_vld),
		.out_root    (sq_root),
		.out_side    (sq_side)
	);

	// stage 6: numerator with rounding term
	logic              vld_s6;
	logic [NUM_W-1:0]  num_s6;
	logic [ROOT_W-1:0] len_s6;
	side_t             side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6  <= NUM_W'({sq_side.nh, 26'd0}) + NUM_W'(sq_root[ROOT_W-1:1]);
			len_s6  <= sq_root;
			side_s6 <= sq_side;
		end
	end

	logic             dv_vld;
	logic [QUO_W-1:0] dv_quo;
	logic             dv_ovf;
	side_t            dv_side;

	bplt_div #(
		.SIDE_W($bits(side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_num    (num_s6),
		.in_den    (len_s6),
		.in_side   (side_s6),
		.out_valid (dv_vld),
		.out_quo   (dv_quo),
		.out_ovf   (dv_ovf),
		.out_side  (dv_side)
	);

	// stage 7: clamped cosine, power chain start
	logic pv_s  [0:PW_N];
	pw_t  pw_s  [0:PW_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s[0] <= 1'b0;
		end else if (en) begin
			pv_s[0] <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_s[0].acc     <= Q30_ONE;
			pw_s[0].prod    <= '0;
			pw_s[0].hh_nz   <= dv_side.hh_nz;
			pw_s[0].diffuse <= dv_side.diffuse;
			pw_s[0].atten   <= dv_side.atten;
			pw_s[0].k       <= dv_side.k;
			if (!dv_side.nh_pos) begin
				pw_s[0].c <= '0;
			end else if (dv_ovf || dv_quo > Q30_CAP) begin
				pw_s[0].c <= Q30_CAP;
			end else begin
				pw_s[0].c <= dv_quo;
			end
		end
	end

	// square, round, multiply by c when the exponent bit is set, round
	for (genvar j = 0; j < EB; j++) begin : g_pow
		localparam int M = 4*j;
		localparam int B = EB-1-j;

		pw_t sq_n;
		pw_t rd_n;
		pw_t ml_n;
		pw_t rc_n;

		for (genvar t = 0; t < 4; t++) begin : g_vld
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pv_s[M+t+1] <= 1'b0;
				end else if (en) begin
					pv_s[M+t+1] <= pv_s[M+t];
				end
			end
		end

		always_comb begin
			sq_n      = pw_s[M];
			sq_n.prod = pw_s[M].acc * pw_s[M].acc;

			rd_n     = pw_s[M+1];
			rd_n.acc = round_cap_q30(pw_s[M+1].prod);

			ml_n      = pw_s[M+2];
			ml_n.prod = pw_s[M+2].k[B] ? (pw_s[M+2].acc * pw_s[M+2].c)
			                           : {32'd0, pw_s[M+2].acc};

			rc_n     = pw_s[M+3];
			rc_n.acc = pw_s[M+3].k[B] ? round_cap_q30(pw_s[M+3].prod)
			                          : pw_s[M+3].prod[Q30_W-1:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pw_s[M+1] <= sq_n;
				pw_s[M+2] <= rd_n;
				pw_s[M+3] <= ml_n;
				pw_s[M+4] <= rc_n;
			end
		end
	end

	// stages 8 and 9: attenuation of the specular term
	logic        vld_s8;
	logic [47:0] sprod_s8;
	logic        hh_nz_s8;
	logic [15:0] diffuse_s8;
	logic        vld_s9;
	logic [15:0] spec_s9;
	logic [15:0] diffuse_s9;
	logic [18:0] s_round;

	assign s_round = {1'b0, sprod_s8[47:30]} + 19'(sprod_s8[29]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s8 <= pv_s[PW_N];
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sprod_s8   <= pw_s[PW_N].acc * pw_s[PW_N].atten;
			hh_nz_s8   <= pw_s[PW_N].hh_nz;
			diffuse_s8 <= pw_s[PW_N].diffuse;
			diffuse_s9 <= diffuse_s8;
			if (!hh_nz_s8) begin
				spec_s9 <= '0;
			end else if (s_round > 19'(Q15_ONE)) begin
				spec_s9 <= Q15_ONE;
			end else begin
				spec_s9 <= s_round[15:0];
			end
		end
	end

	// two-entry output queue
	logic [31:0] fifo_q [0:1];
	logic        wr_q;
	logic        rd_q;

	assign push     = en && vld_s9;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= {spec_s9, diffuse_s9};
		end
	end

	`BPLT_NEVER(a_no_push_when_full, push && cnt_q == 2'd2)
	`BPLT_NEVER(a_cnt_bound, cnt_q == 2'd3)
	`BPLT_CHECK(a_out_range, m_tvalid |-> (m_tdata[15:0] <= 16'd32768 && m_tdata[31:16] <= 16'd32768))
endmodule

// File: hw/rtl/bplt_isqrt.sv
module bplt_isqrt
	import bplt_pkg::*;
#(
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  in_radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);
	localparam int N = ROOT_W;

	logic              vld_s  [0:N];
	logic [RAD_W-1:0]  rad_s  [0:N];
	logic [29:0]       rem_s  [0:N];
	logic [ROOT_W-1:0] root_s [0:N];
	logic [SIDE_W-1:0] side_s [0:N];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = in_radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	// one result bit per stage, two radicand bits consumed each time
	for (genvar i = 0; i < N; i++) begin : g_step
		logic [29:0] rem_try;
		logic [29:0] trial;
		logic        take;

		always_comb begin
			rem_try = {rem_s[i][27:0], rad_s[i][2*(N-1-i) +: 2]};
			trial   = {1'b0, root_s[i], 2'b01};
			take    = (rem_try >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= rad_s[i];
				side_s[i+1] <= side_s[i];
				rem_s[i+1]  <= take ? (rem_try - trial) : rem_try;
				root_s[i+1] <= {root_s[i][ROOT_W-2:0], take};
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N];
	assign out_side  = side_s[N];
endmodule

// File: hw/rtl/bplt_div.sv
module bplt_div
	import bplt_pkg::*;
#(
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [ROOT_W-1:0] in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  out_quo,
	output logic              out_ovf,
	output logic [SIDE_W-1:0] out_side
);
	localparam int N = QUO_W;

	logic              vld_s  [0:N];
	logic [ROOT_W-1:0] rem_s  [0:N];
	logic [QUO_W-1:0]  low_s  [0:N];
	logic [QUO_W-1:0]  quo_s  [0:N];
	logic [ROOT_W-1:0] den_s  [0:N];
	logic              ovf_s  [0:N];
	logic [SIDE_W-1:0] side_s [0:N];

	// quotient of 2^32 or more is flagged up front, then the top part is below den
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= (in_num >= {1'b0, in_den, {QUO_W{1'b0}}});
			rem_s[0]  <= in_num[NUM_W-2:QUO_W];
			low_s[0]  <= in_num[QUO_W-1:0];
			quo_s[0]  <= '0;
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [ROOT_W:0] t;
		logic            take;

		always_comb begin
			t    = {rem_s[i], low_s[i][QUO_W-1]};
			take = (t >= {1'b0, den_s[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? ROOT_W'(t - {1'b0, den_s[i]}) : t[ROOT_W-1:0];
				low_s[i+1]  <= {low_s[i][QUO_W-2:0], 1'b0};
				quo_s[i+1]  <= {quo_s[i][QUO_W-2:0], take};
				den_s[i+1]  <= den_s[i];
				ovf_s[i+1]  <= ovf_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_quo   = quo_s[N];
	assign out_ovf   = ovf_s[N];
	assign out_side  = side_s[N];
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bplt_pkg::*;

	localparam int IN_W = 168;
	localparam int RAND_HITS = 700;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic [IN_W-1:0] hit;
		bit typed;
		logic [31:0] terms;
	} hit_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;

	logic [31:0] terms_due[$];
	hit_row_t hit_rows[$];
	int errors = 0;
	bit calm = 0;
	bit stim_done = 0;

	blinn_phong_light_terms dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [IN_W-1:0] pack_hit(input int nx, input int ny, input int nz,
			input int lx, input int ly, input int lz, input int vx, input int vy,
			input int vz, input int at, input int k);
		logic [IN_W-1:0] d;
		d = '0;
		d[15:0] = nx[15:0];
		d[31:16] = ny[15:0];
		d[47:32] = nz[15:0];
		d[63:48] = lx[15:0];
		d[79:64] = ly[15:0];
		d[95:80] = lz[15:0];
		d[111:96] = vx[15:0];
		d[127:112] = vy[15:0];
		d[143:128] = vz[15:0];
		d[159:144] = at[15:0];
		d[167:160] = k[7:0];
		return d;
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned q30_product(input longint unsigned a,
			input longint unsigned b);
		longint unsigned r;
		r = (a * b + (64'd1 << 29)) >> 30;
		return (r > 64'(Q30_CAP)) ? 64'(Q30_CAP) : r;
	endfunction

	function automatic longint unsigned scale_by_atten(input longint unsigned v,
			input int sh, input longint unsigned at);
		longint unsigned r;
		r = (v * at + (64'd1 << (sh - 1))) >> sh;
		return (r > 64'(Q15_ONE)) ? 64'(Q15_ONE) : r;
	endfunction

	// packed {specular, diffuse}
	function automatic logic [31:0] light_terms(input logic [IN_W-1:0] d);
		longint nl, nh, hh, n, l, h;
		longint unsigned at, c, acc, len, diff, spec;
		logic [7:0] k;
		nl = 0;
		nh = 0;
		hh = 0;
		diff = 0;
		spec = 0;
		at = d[159:144];
		k = d[167:160];
		for (int i = 0; i < 3; i++) begin
			n = longint'($signed(d[16*i +: 16]));
			l = longint'($signed(d[48+16*i +: 16]));
			h = l + longint'($signed(d[96+16*i +: 16]));
			nl += n * l;
			nh += n * h;
			hh += h * h;
		end
		if (nl > 0)
			diff = scale_by_atten(longint'(nl), 28, at);
		if (hh > 0) begin
			c = 0;
			acc = 64'(Q30_ONE);
			if (nh > 0) begin
				len = floor_root(longint'(hh) << 20);
				c = ((longint'(nh) << 26) + len / 2) / len;
				if (c > 64'(Q30_CAP))
					c = 64'(Q30_CAP);
			end
			for (int b = 7; b >= 0; b--) begin
				acc = q30_product(acc, acc);
				if (k[b])
					acc = q30_product(acc, c);
			end
			spec = scale_by_atten(acc, 30, at);
		end
		return {spec[15:0], diff[15:0]};
	endfunction

	task automatic add_row(input logic [IN_W-1:0] d, input bit typed, input logic [31:0] t);
		hit_row_t r;
		r.hit = d;
		r.typed = typed;
		r.terms = t;
		hit_rows.push_back(r);
	endtask

	// random direction scaled to unit length in q2.14
	task automatic unit_dir(output int x, output int y, output int z);
		real a, b, c, m;
		a = real'($urandom_range(2000)) - 1000.0;
		b = real'($urandom_range(2000)) - 1000.0;
		c = real'($urandom_range(2000)) - 1000.0;
		m = $sqrt(a * a + b * b + c * c);
		if (m < 1.0) begin
			a = 0.0;
			b = 0.0;
			c = 1000.0;
			m = 1000.0;
		end
		x = int'(a / m * 16384.0);
		y = int'(b / m * 16384.0);
		z = int'(c / m * 16384.0);
	endtask

	task automatic send_hit(input hit_row_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(6);
		repeat (gap) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = r.hit;
		do @(posedge clk); while (!s_tready);
		terms_due.push_back(r.typed ? r.terms : light_terms(r.hit));
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	initial begin
		hit_row_t r;
		int nx, ny, nz, lx, ly, lz, vx, vy, vz, at, k, mode;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_row(pack_hit(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 32'h0000_0000);
		add_row(pack_hit(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 32768, 0), 1,
			{Q15_ONE, Q15_ONE});
		add_row(pack_hit(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 32768, 255), 0, '0);
		add_row(pack_hit(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 32768, 1), 0, '0);
		// half vector cancels out
		add_row(pack_hit(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 32768, 7), 1,
			{16'd0, Q15_ONE});
		// light behind the surface
		add_row(pack_hit(0, 0, 16384, 0, 0, -16384, 0, 0, 16384, 32768, 3), 1, 32'h0);
		// zero exponent with attenuation above one
		add_row(pack_hit(0, 0, 16384, 0, 0, -16384, 16384, 0, 0, 40000, 0), 1,
			{Q15_ONE, 16'd0});
		// half vector perpendicular to the normal
		add_row(pack_hit(16384, 0, 0, 0, 16384, 0, 0, 16384, 0, 32768, 5), 1, 32'h0);
		add_row(pack_hit(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 65535, 255), 0, '0);
		add_row(pack_hit(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			65535, 255), 0, '0);
		add_row(pack_hit(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
			32767, 65535, 1), 0, '0);
		add_row(pack_hit(11585, 0, 11585, 0, 0, 16384, 16384, 0, 0, 20000, 32), 0, '0);
		add_row(pack_hit(0, 16384, 0, 0, 16384, 0, 0, 16384, 0, 0, 200), 1, 32'h0);

		foreach (hit_rows[i])
			send_hit(hit_rows[i]);

		for (int i = 0; i < RAND_HITS; i++) begin
			if (i % 60 == 0)
				calm = ($urandom_range(3) == 0);
			mode = $urandom_range(9);
			at = ($urandom_range(4) == 0) ? 32768 : $urandom_range(65535);
			k = $urandom_range(255);
			if ($urandom_range(5) == 0)
				k = $urandom_range(4);
			unit_dir(nx, ny, nz);
			unit_dir(lx, ly, lz);
			unit_dir(vx, vy, vz);
			if (mode == 0) begin
				vx = -lx;
				vy = -ly;
				vz = -lz;
			end
			r.typed = 0;
			r.terms = '0;
			if (mode >= 8) begin
				r.hit = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom()});
				r.hit[167:160] = k[7:0];
			end else begin
				r.hit = pack_hit(nx, ny, nz, lx, ly, lz, vx, vy, vz, at, k);
			end
			send_hit(r);
		end
		stim_done = 1;
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(6);
			repeat (stall) begin
				m_tready = 1'b0;
				@(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (terms_due.size() == 0) begin
				$display("%0t: result with none pending, got %h", $time, m_tdata);
				errors++;
			end else begin
				logic [31:0] want;
				want = terms_due.pop_front();
				if (m_tdata[15:0] !== want[15:0]) begin
					$display("%0t: diffuse_term expected %0d actual %0d", $time,
						want[15:0], m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== want[31:16]) begin
					$display("%0t: specular_term expected %0d actual %0d", $time,
						want[31:16], m_tdata[31:16]);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (terms_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d results pending", $time, terms_due.size());
		$display("tb_top NOT OK");
		$finish;
	end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bplt_pkg.sv
hw/rtl/bplt_isqrt.sv
hw/rtl/bplt_div.sv
hw/rtl/blinn_phong_light_terms.sv
verif/tb_top.sv
